FILE: rtl/baace_pkg.sv
// Package for the block-average ANSI color emitter.
// Holds character codes, register indexes and widths; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package baace_pkg;
    localparam int unsigned MAX_WIDTH_DEF       = 2048;
    localparam int unsigned MAX_CELL_HEIGHT_DEF = 2048;
    localparam int unsigned REG_W   = 12;
    localparam int unsigned SUM_W   = 30;
    localparam int unsigned AREA_W  = 24;
    localparam int unsigned IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
    localparam logic [IDX_W-1:0] REG_CELL_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] REG_CELL_HEIGHT = 2'd2;

    localparam logic [7:0] CH_ESC   = 8'd27;
    localparam logic [7:0] CH_LBR   = 8'd91;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_M     = 8'd109;
    localparam logic [7:0] CH_FOUR  = 8'd52;
    localparam logic [7:0] CH_EIGHT = 8'd56;
    localparam logic [7:0] CH_SEMI  = 8'd59;
    localparam logic [7:0] CH_TWO   = 8'd50;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_NL    = 8'd10;
endpackage
`default_nettype wire

FILE: rtl/block_average_ansi_color_emitter.sv
// Top level of the block-average ANSI color emitter: column sum memories,
// a shared restoring divider and a character sequencer. Uses baace_pkg.
//
// channel | dir | handshake          | payload
// --------+-----+--------------------+---------------------------------------
// s_axis  | in  | tvalid/tready      | tdata[23:0] = red, green, blue
// m_axis  | out | tvalid/tready      | tdata[7:0] = char_code, tlast = last_char
// cfg     | in  | i_cfg_we           | i_cfg_index, i_cfg_data[11:0]
//
// Steps: a pixel that closes no cell and no row goes through accept, read,
// add/write and build. A closing pixel adds three divider passes, one quotient
// bit per cycle in a single shared subtractor, and any pixel that emits then
// sends its characters one by one. Output stalls hold the sequencer. Reset
// is synchronous, active low; the column sums need no clearing since the
// first pixel of a cell writes them.
`timescale 1ns / 1ps
`default_nettype none
module block_average_ansi_color_emitter #(
    parameter int unsigned MAX_WIDTH       = baace_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_CELL_HEIGHT = baace_pkg::MAX_CELL_HEIGHT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // char_code[7:0]
    output logic             m_axis_tlast,   // last_char
    input  wire logic        i_cfg_we,
    input  wire logic [baace_pkg::IDX_W-1:0] i_cfg_index,
    input  wire logic [baace_pkg::REG_W-1:0] i_cfg_data
);
    localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned SW = baace_pkg::SUM_W;
    localparam int unsigned RW = baace_pkg::REG_W;
    localparam int unsigned HW = (MAX_CELL_HEIGHT > 1) ? $clog2(MAX_CELL_HEIGHT) : 1;
    localparam int unsigned HCW = HW + 1;

    localparam logic [3:0] S_IDLE = 4'd0, S_READ = 4'd1, S_ADD = 4'd2,
        S_DIV = 4'd3, S_CMP = 4'd4, S_EMIT = 4'd5;

    // character script codes
    localparam logic [4:0] K_ESC = 5'd0, K_LBR = 5'd1, K_ZERO = 5'd2, K_M = 5'd3,
        K_FOUR = 5'd4, K_EIGHT = 5'd5, K_SEMI = 5'd6, K_TWO = 5'd7,
        K_DR = 5'd8, K_DG = 5'd9, K_DB = 5'd10, K_SPACE = 5'd11, K_NL = 5'd12,
        K_END = 5'd13;

    logic [RW-1:0] r_img_w, r_cell_w, r_cell_h;
    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_pix_col, r_col_in_cell, r_idx;
    logic [HW-1:0] r_row_in_cell;
    logic [23:0]   r_pixel, r_prev;
    logic [SW-1:0] r_rd_r, r_rd_g, r_rd_b;
    logic          r_first, r_cell_last, r_row_end;
    logic [SW-1:0] r_sum [3];
    logic [SW-1:0] r_rem;
    logic [SW-1:0] r_quo;
    logic [4:0]    r_bit;
    logic [1:0]    r_chan;
    logic [7:0]    r_avg [3];
    logic [4:0]    r_script [24];
    logic [4:0]    r_pc, r_len;
    logic [7:0]    r_out_char;
    logic          r_out_valid, r_out_last;

    logic [SW-1:0] mem_r [MAX_WIDTH];
    logic [SW-1:0] mem_g [MAX_WIDTH];
    logic [SW-1:0] mem_b [MAX_WIDTH];

    // effective bounds
    localparam int unsigned AREA_WL = baace_pkg::AREA_W;
    logic [RW:0]   eff_w, eff_cw, eff_ch;
    logic [AREA_WL-1:0] area;
    always_comb begin
        eff_w  = (r_img_w == '0) ? (RW+1)'(1) : {1'b0, r_img_w};
        if ({19'd0, eff_w} > MAX_WIDTH) eff_w = (RW+1)'(MAX_WIDTH);
        eff_cw = (r_cell_w == '0) ? (RW+1)'(1) : {1'b0, r_cell_w};
        if (eff_cw > eff_w) eff_cw = eff_w;
        eff_ch = (r_cell_h == '0) ? (RW+1)'(1) : {1'b0, r_cell_h};
        if ({19'd0, eff_ch} > MAX_CELL_HEIGHT) eff_ch = (RW+1)'(MAX_CELL_HEIGHT);
    end
    logic [AREA_WL-1:0] r_area;

    // clamped position for this pixel
    logic [RW:0] pc_c, cic_c;
    always_comb begin
        pc_c = (RW+1)'(r_pix_col);
        if (pc_c >= eff_w) pc_c = eff_w - 1'b1;
        cic_c = (RW+1)'(r_col_in_cell);
        if (cic_c > pc_c) cic_c = pc_c;
    end

    // shared restoring divider: one quotient bit per cycle
    logic [SW:0]   trial;
    logic [SW-1:0] rem_sh;
    always_comb begin
        rem_sh = {r_rem[SW-2:0], r_sum[r_chan][r_bit]};
        trial  = {1'b0, rem_sh} - {{(SW+1-AREA_WL){1'b0}}, r_area};
    end
    assign area = AREA_WL'(eff_cw) * AREA_WL'(eff_ch);

    // decimal digit helpers: hundreds and tens by compare, ones by subtract
    function automatic logic [7:0] dig(input logic [7:0] v, input logic [1:0] k);
        logic [7:0] h, t, o, rm;
        h = (v >= 8'd200) ? 8'd2 : (v >= 8'd100) ? 8'd1 : 8'd0;
        rm = v - 8'(h * 8'd100);
        t = 8'd0;
        for (int i = 1; i < 10; i++) begin
            if (rm >= 8'(i * 10)) t = 8'(i);
        end
        o = rm - 8'(t * 8'd10);
        unique case (k)
            2'd0:    dig = h;
            2'd1:    dig = t;
            default: dig = o;
        endcase
    endfunction

    logic [23:0] color;
    assign color = {r_avg[0], r_avg[1], r_avg[2]};

    logic [1:0] r_dig_k;
    logic [7:0] cur_val;
    logic [4:0] cur_code;
    always_comb begin
        cur_code = r_script[r_pc];
        cur_val = (cur_code == K_DR) ? r_avg[0] : (cur_code == K_DG) ? r_avg[1] : r_avg[2];
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_char;
    assign m_axis_tlast  = r_out_last;

    logic out_free;
    assign out_free = !r_out_valid || m_axis_tready;

    // build the character list for a closed cell and/or row end
    task automatic push(inout logic [4:0] n, input logic [4:0] k);
        r_script[n] <= k;
        n = n + 5'd1;
    endtask

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= RW'(1); r_cell_w <= RW'(1); r_cell_h <= RW'(1);
            r_state <= S_IDLE; r_pix_col <= '0; r_col_in_cell <= '0;
            r_row_in_cell <= '0; r_prev <= '0; r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    baace_pkg::REG_IMAGE_WIDTH: r_img_w  <= i_cfg_data;
                    baace_pkg::REG_CELL_WIDTH:  r_cell_w <= i_cfg_data;
                    baace_pkg::REG_CELL_HEIGHT: r_cell_h <= i_cfg_data;
                    default: ;
                endcase
            end
            // drop a taken character; the emit step reloads the register itself
            if (r_out_valid && m_axis_tready && (r_state != S_EMIT)) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_pixel <= s_axis_tdata;
                        r_idx   <= CW'(pc_c - cic_c);
                        r_first <= (r_row_in_cell == '0) && (cic_c == '0);
                        r_cell_last <= (cic_c + 1'b1 >= eff_cw) &&
                                       (HCW'(r_row_in_cell) + 1'b1 >= HCW'(eff_ch));
                        r_area  <= area;
                        // advance counters
                        if (pc_c + 1'b1 >= eff_w) begin
                            r_pix_col <= '0; r_col_in_cell <= '0;
                            if (HCW'(r_row_in_cell) + 1'b1 >= HCW'(eff_ch)) begin
                                r_row_in_cell <= '0; r_row_end <= 1'b1;
                            end else begin
                                r_row_in_cell <= r_row_in_cell + 1'b1; r_row_end <= 1'b0;
                            end
                        end else begin
                            r_pix_col <= CW'(pc_c + 1'b1);
                            r_col_in_cell <= (cic_c + 1'b1 >= eff_cw) ? '0 : CW'(cic_c + 1'b1);
                            r_row_end <= 1'b0;
                        end
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_ADD;
                S_ADD: begin
                    r_sum[0] <= r_first ? SW'(r_pixel[7:0])   : r_rd_r + SW'(r_pixel[7:0]);
                    r_sum[1] <= r_first ? SW'(r_pixel[15:8])  : r_rd_g + SW'(r_pixel[15:8]);
                    r_sum[2] <= r_first ? SW'(r_pixel[23:16]) : r_rd_b + SW'(r_pixel[23:16]);
                    r_chan <= 2'd0; r_bit <= 5'(SW-1); r_rem <= '0;
                    r_state <= r_cell_last ? S_DIV : S_CMP;
                end
                S_DIV: begin
                    r_quo <= {r_quo[SW-2:0], !trial[SW]};
                    if (r_bit == '0) begin
                        r_avg[r_chan] <= {r_quo[6:0], !trial[SW]};
                        r_rem <= '0; r_bit <= 5'(SW-1);
                        if (r_chan == 2'd2) r_state <= S_CMP;
                        else r_chan <= r_chan + 2'd1;
                    end else begin
                        r_rem <= trial[SW] ? rem_sh : trial[SW-1:0];
                        r_bit <= r_bit - 5'd1;
                    end
                end
                S_CMP: begin : build
                    logic [4:0] n;
                    logic [23:0] pv;
                    n = '0; pv = r_prev;
                    if (r_cell_last) begin
                        if (color != pv) begin
                            if (color == '0) begin
                                push(n, K_ESC); push(n, K_LBR); push(n, K_ZERO); push(n, K_M);
                            end else begin
                                push(n, K_ESC); push(n, K_LBR); push(n, K_FOUR);
                                push(n, K_EIGHT); push(n, K_SEMI); push(n, K_TWO);
                                push(n, K_SEMI); push(n, K_DR); push(n, K_SEMI);
                                push(n, K_DG); push(n, K_SEMI); push(n, K_DB); push(n, K_M);
                            end
                            pv = color;
                        end
                        push(n, K_SPACE);
                    end
                    if (r_row_end) begin
                        if (pv != '0) begin
                            push(n, K_ESC); push(n, K_LBR); push(n, K_ZERO); push(n, K_M);
                        end
                        push(n, K_NL);
                        pv = '0;
                    end
                    r_prev <= pv; r_len <= n; r_pc <= '0;
                    r_dig_k <= (color[23:16] >= 8'd100) ? 2'd0 : (color[23:16] >= 8'd10) ? 2'd1 : 2'd2;
                    r_state <= (n == '0) ? S_IDLE : S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        logic [7:0] ch;
                        logic step;
                        step = 1'b1; ch = baace_pkg::CH_SPACE;
                        case (cur_code)
                            K_ESC:   ch = baace_pkg::CH_ESC;
                            K_LBR:   ch = baace_pkg::CH_LBR;
                            K_ZERO:  ch = baace_pkg::CH_ZERO;
                            K_M:     ch = baace_pkg::CH_M;
                            K_FOUR:  ch = baace_pkg::CH_FOUR;
                            K_EIGHT: ch = baace_pkg::CH_EIGHT;
                            K_SEMI:  ch = baace_pkg::CH_SEMI;
                            K_TWO:   ch = baace_pkg::CH_TWO;
                            K_DR, K_DG, K_DB: begin
                                ch = baace_pkg::CH_ZERO + dig(cur_val, r_dig_k);
                                step = (r_dig_k == 2'd2);
                            end
                            K_NL:    ch = baace_pkg::CH_NL;
                            default: ch = baace_pkg::CH_SPACE;
                        endcase
                        r_out_char <= ch; r_out_valid <= 1'b1;
                        r_out_last <= step && (r_pc + 5'd1 == r_len);
                        if (!step) r_dig_k <= r_dig_k + 2'd1;
                        else begin
                            logic [7:0] nv;
                            logic [4:0] nc;
                            nc = r_script[r_pc + 5'd1];
                            nv = (nc == K_DR) ? r_avg[0] : (nc == K_DG) ? r_avg[1] : r_avg[2];
                            r_dig_k <= (nv >= 8'd100) ? 2'd0 : (nv >= 8'd10) ? 2'd1 : 2'd2;
                            r_pc <= r_pc + 5'd1;
                            if (r_pc + 5'd1 == r_len) r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // column sum memories: read in S_READ, write in S_ADD
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rd_r <= mem_r[r_idx]; r_rd_g <= mem_g[r_idx]; r_rd_b <= mem_b[r_idx];
        end
        if (r_state == S_ADD) begin
            mem_r[r_idx] <= r_first ? SW'(r_pixel[7:0])   : r_rd_r + SW'(r_pixel[7:0]);
            mem_g[r_idx] <= r_first ? SW'(r_pixel[15:8])  : r_rd_g + SW'(r_pixel[15:8]);
            mem_b[r_idx] <= r_first ? SW'(r_pixel[23:16]) : r_rd_b + SW'(r_pixel[23:16]);
        end
    end

    // input is taken only while idle
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (r_state == S_IDLE)) else $error("ready outside idle");
    // a pixel always moves to the read step
    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_READ)) else $error("no read");
    // a stalled character holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata)) else $error("char moved");
endmodule
`default_nettype wire

FILE: test/block_average_ansi_color_emitter_tb.sv
// Testbench for block_average_ansi_color_emitter: pixel stream in, ANSI character stream out.
// Checks every character against a built-in predictor or a given expected string. Depends on baace_pkg and the RTL.
`timescale 1ns / 1ps
module block_average_ansi_color_emitter_tb;

    localparam int MAXW = baace_pkg::MAX_WIDTH_DEF;
    localparam int MAXH = baace_pkg::MAX_CELL_HEIGHT_DEF;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_char;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [23:0]      s_axis_tdata = '0;   // red[7:0], green[15:8], blue[23:16]
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [7:0]       m_axis_tdata;        // char_code[7:0]
    logic             m_axis_tlast;        // last_char
    logic             i_cfg_we = 1'b0;
    logic [baace_pkg::IDX_W-1:0] i_cfg_index = '0;
    logic [baace_pkg::REG_W-1:0] i_cfg_data = '0;

    block_average_ansi_color_emitter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state: running cell sums per column, last emitted color, raster counters.
    logic [29:0] red_sum [0:MAXW-1];
    logic [29:0] green_sum [0:MAXW-1];
    logic [29:0] blue_sum [0:MAXW-1];
    logic [23:0] shown_rgb = '0;
    int          px_col = 0;
    int          col_in_cell = 0;
    int          row_in_cell = 0;
    logic [11:0] reg_width = 12'd1;
    logic [11:0] reg_cell_w = 12'd1;
    logic [11:0] reg_cell_h = 12'd1;

    logic [7:0]  burst [$];      // characters caused by the pixel being predicted
    t_char       pending_chars [$];
    int          errors = 0;
    bit          rx_calm = 1'b0;
    int          rx_hold = 0;
    int          rx_stall = 0;

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int eff_width(logic [11:0] v);
        if (v == 0) return 1;
        return (v > MAXW) ? MAXW : int'(v);
    endfunction

    function automatic int eff_height(logic [11:0] v);
        if (v == 0) return 1;
        return (v > MAXH) ? MAXH : int'(v);
    endfunction

    function automatic void push_reset_seq();
        burst.push_back(baace_pkg::CH_ESC);
        burst.push_back(baace_pkg::CH_LBR);
        burst.push_back(baace_pkg::CH_ZERO);
        burst.push_back(baace_pkg::CH_M);
    endfunction

    // Decimal without leading zeros.
    function automatic void push_decimal(logic [7:0] v);
        if (v >= 100) burst.push_back(baace_pkg::CH_ZERO + 8'(v / 100));
        if (v >= 10) burst.push_back(baace_pkg::CH_ZERO + 8'((v / 10) % 10));
        burst.push_back(baace_pkg::CH_ZERO + 8'(v % 10));
    endfunction

    // Advance the predictor by one pixel; leaves the characters it causes in burst.
    function automatic void predict_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int w, cw, ch, idx, area;
        logic [7:0] ar, ag, ab;
        logic [23:0] rgb;
        bit row_end;
        w = eff_width(reg_width);
        cw = (reg_cell_w == 0) ? 1 : int'(reg_cell_w);
        if (cw > w) cw = w;
        ch = eff_height(reg_cell_h);
        burst.delete();

        if (px_col >= w) px_col = w - 1;
        if (col_in_cell > px_col) col_in_cell = px_col;
        idx = px_col - col_in_cell;
        if (row_in_cell == 0 && col_in_cell == 0) begin
            red_sum[idx] = 30'(r);
            green_sum[idx] = 30'(g);
            blue_sum[idx] = 30'(b);
        end else begin
            red_sum[idx] = red_sum[idx] + 30'(r);
            green_sum[idx] = green_sum[idx] + 30'(g);
            blue_sum[idx] = blue_sum[idx] + 30'(b);
        end

        // Last pixel of a cell: average the cell and emit its color if it changed.
        if (col_in_cell + 1 >= cw && row_in_cell + 1 >= ch) begin
            area = cw * ch;
            ar = 8'(int'(red_sum[idx]) / area);
            ag = 8'(int'(green_sum[idx]) / area);
            ab = 8'(int'(blue_sum[idx]) / area);
            rgb = {ar, ag, ab};
            if (rgb != shown_rgb) begin
                if (rgb == 0) begin
                    push_reset_seq();
                end else begin
                    burst.push_back(baace_pkg::CH_ESC);
                    burst.push_back(baace_pkg::CH_LBR);
                    burst.push_back(baace_pkg::CH_FOUR);
                    burst.push_back(baace_pkg::CH_EIGHT);
                    burst.push_back(baace_pkg::CH_SEMI);
                    burst.push_back(baace_pkg::CH_TWO);
                    burst.push_back(baace_pkg::CH_SEMI);
                    push_decimal(ar);
                    burst.push_back(baace_pkg::CH_SEMI);
                    push_decimal(ag);
                    burst.push_back(baace_pkg::CH_SEMI);
                    push_decimal(ab);
                    burst.push_back(baace_pkg::CH_M);
                end
                shown_rgb = rgb;
            end
            burst.push_back(baace_pkg::CH_SPACE);
        end

        col_in_cell++;
        if (col_in_cell >= cw) col_in_cell = 0;
        px_col++;
        row_end = 1'b0;
        if (px_col >= w) begin
            px_col = 0;
            col_in_cell = 0;
            row_in_cell++;
            if (row_in_cell >= ch) begin
                row_in_cell = 0;
                row_end = 1'b1;
            end
        end

        // End of a cell row: drop the background color and start a new line.
        if (row_end) begin
            if (shown_rgb != 0) push_reset_seq();
            burst.push_back(baace_pkg::CH_NL);
            shown_rgb = '0;
        end
    endfunction

    // Offer one pixel after the given gap and hold it until the transaction happens.
    // A non-empty want overrides the predicted characters.
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, string want, int gap);
        int i;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata <= {b, g, r};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_pixel(r, g, b);
        if (want.len() != 0) begin
            burst.delete();
            for (i = 0; i < want.len(); i++) burst.push_back(want[i]);
        end
        for (i = 0; i < burst.size(); i++)
            pending_chars.push_back('{code: burst[i], last: (i == burst.size() - 1)});
    endtask

    // Stop offering, let every expected character arrive, then let the block settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [11:0] w, logic [11:0] cw, logic [11:0] ch);
        i_cfg_we <= 1'b1;
        i_cfg_index <= baace_pkg::REG_IMAGE_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_index <= baace_pkg::REG_CELL_WIDTH;
        i_cfg_data <= cw;
        @(posedge i_clk);
        i_cfg_index <= baace_pkg::REG_CELL_HEIGHT;
        i_cfg_data <= ch;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        reg_width = w;
        reg_cell_w = cw;
        reg_cell_h = ch;
    endtask

    // Send whole cell rows so that every phase ends with the counters back at zero.
    // Content per cell row: black, one fixed color, near black, or random.
    task automatic send_cell_rows(int rows, bit calm, inout int sent);
        int n, i, mode;
        logic [23:0] fixed;
        n = eff_width(reg_width) * eff_height(reg_cell_h);
        rx_calm = calm;
        fixed = 24'($urandom);
        repeat (rows) begin
            mode = $urandom_range(0, 3);
            for (i = 0; i < n; i++) begin
                case (mode)
                    0: send_pixel(8'd0, 8'd0, 8'd0, "", calm ? 0 : gap_len());
                    1: send_pixel(fixed[7:0], fixed[15:8], fixed[23:16], "",
                                  calm ? 0 : gap_len());
                    2: send_pixel(8'($urandom_range(0, 1)), 8'($urandom_range(0, 1)),
                                  8'($urandom_range(0, 1)), "", calm ? 0 : gap_len());
                    default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom), "",
                                        calm ? 0 : gap_len());
                endcase
                sent++;
            end
        end
        drain();
    endtask

    // Receiver: check each character transaction, then pick the next tready.
    always @(posedge i_clk) begin
        t_char want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected char expected none got %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
                errors++;
            end else begin
                want = pending_chars.pop_front();
                if (m_axis_tdata !== want.code || m_axis_tlast !== want.last) begin
                    $display("%0t: char mismatch expected %h/%b got %h/%b", $time,
                             want.code, want.last, m_axis_tdata, m_axis_tlast);
                    errors++;
                end
            end
        end
        if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold--;
        end else if (rx_stall > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall--;
        end else if (rx_calm || $urandom_range(0, 99) < 75) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= 1'b0;
            rx_stall = gap_len();
        end
    end

    initial begin
        logic [23:0] dir_px [$];
        string       dir_want [$];
        int          i, sent, w;
        dir_px = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
                   24'h030201, 24'h64630A, 24'h010000, 24'h204080, 24'h7F7F7F,
                   24'h80FE01, 24'h000000};
        // One pixel per cell and per row at reset sizes: the color, a space, the row tail.
        dir_want = '{" \n",
                     "\033[48;2;255;255;255m \033[0m\n",
                     "\033[48;2;255;0;0m \033[0m\n",
                     "\033[48;2;0;255;0m \033[0m\n",
                     "\033[48;2;0;0;255m \033[0m\n",
                     "", "", "", "", "", "",
                     " \n"};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rx_calm = 1'b0;
        for (i = 0; i < dir_px.size(); i++)
            send_pixel(dir_px[i][7:0], dir_px[i][15:8], dir_px[i][23:16], dir_want[i], gap_len());
        drain();

        sent = 0;
        // Zero registers act as one.
        write_regs(12'd0, 12'd0, 12'd0);
        send_cell_rows(3, 1'b0, sent);

        // Long receiver hold-off while pixels keep coming: the block must stall its input.
        write_regs(12'd8, 12'd2, 12'd2);
        rx_hold = 400;
        send_cell_rows(2, 1'b1, sent);

        // Cell width not dividing the row: the partial cell stays silent.
        write_regs(12'd6, 12'd4, 12'd1);
        send_cell_rows(2, 1'b0, sent);
        write_regs(12'd7, 12'd3, 12'd2);
        send_cell_rows(2, 1'b0, sent);

        // Cell height change in the first row of a cell row: the sender pauses until idle.
        write_regs(12'd4, 12'd2, 12'd3);
        send_pixel(8'd200, 8'd10, 8'd7, "", gap_len());
        send_pixel(8'd100, 8'd11, 8'd255, "", gap_len());
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= baace_pkg::REG_CELL_HEIGHT;
        i_cfg_data <= 12'd1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        reg_cell_h = 12'd1;
        send_pixel(8'd5, 8'd250, 8'd0, "", gap_len());
        send_pixel(8'd6, 8'd251, 8'd1, "", gap_len());
        drain();

        // Cell width past the image width clamps to the row.
        write_regs(12'd4, 12'hFFF, 12'd1);
        send_cell_rows(1, 1'b1, sent);

        // Random sizes, mostly small.
        while (sent < 160) begin
            w = $urandom_range(1, 12);
            write_regs(12'(w), 12'($urandom_range(0, w + 2)), 12'($urandom_range(0, 4)));
            send_cell_rows($urandom_range(1, 2), $urandom_range(0, 3) == 0, sent);
        end

        rx_calm = 1'b1;
        repeat (50) @(posedge i_clk);
        while (pending_chars.size() != 0) begin
            $display("%0t: missing char expected %h/%b got none", $time,
                     pending_chars[0].code, pending_chars[0].last);
            void'(pending_chars.pop_front());
            errors++;
        end
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/baace_pkg.sv
rtl/block_average_ansi_color_emitter.sv
test/block_average_ansi_color_emitter_tb.sv
